// ===== rtl/core/imu_pkt_pkg.sv =====
// Shared types and constants for the IMU FIFO packet parser.
// No dependencies; imported by every module of the block.
package imu_pkt_pkg;

	localparam int FIFO_BYTES_DEF = 2048;
	localparam int PKT_LEN = 20;
	localparam int POS_W = $clog2(PKT_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PKT_LEN - 1);

	localparam int CNT_W = 16;
	localparam int PER_W = 16;
	localparam int TS_W = 64;
	// count/20 = (count>>2)/5, exact via reciprocal multiply for 16-bit counts
	localparam int PKTS_W = 12;
	localparam logic [15:0] DIV5_MAGIC = 16'd52429;
	localparam int DIV5_SHIFT = 18;
	localparam int DIV_PROD_W = CNT_W - 2 + 16;

	localparam logic [PER_W-1:0] PERIOD_RST = 16'd500;

	// header: bit 7 clear, bits 6..4 set, bits 3..2 = 2'b10
	localparam logic [7:0] HDR_MASK = 8'hfc;
	localparam logic [7:0] HDR_GOOD = 8'h78;
	localparam logic [19:0] INVALID20 = 20'h80000;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [1:0] ST_SAMPLE = 2'd0;
	localparam logic [1:0] ST_LOST = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic [1:0] REG_ACCEL_EN = 2'd0;
	localparam logic [1:0] REG_GYRO_EN = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	typedef logic [PKT_LEN-1:0][7:0] pkt_t;

	typedef struct packed {
		logic hdr_ok;
		logic acc_bad;
		logic [19:0] ax;
		logic [19:0] ay;
		logic [19:0] az;
		logic [19:0] gx;
		logic [19:0] gy;
		logic [19:0] gz;
		logic [15:0] temp;
	} smp_t;

	typedef struct packed {
		logic load;
		logic [TS_W-1:0] value;
	} ts_load_t;

endpackage

// ===== rtl/core/imu_pkt_decode.sv =====
// Packet field decode: header check and 20-bit accel/gyro rebuild.
// Depends on imu_pkt_pkg.
module imu_pkt_decode import imu_pkt_pkg::*; (
	input  pkt_t pkt,
	output smp_t smp
);

	function automatic logic [19:0] join20(input logic [7:0] hi, input logic [7:0] mid,
		input logic [3:0] lo);
		return {hi, mid, lo};
	endfunction

	always_comb begin
		smp.hdr_ok = (pkt[0] & HDR_MASK) == HDR_GOOD;
		// low nibbles: accel in upper half, gyro in lower half of bytes 17..19
		smp.ax = join20(pkt[1], pkt[2], pkt[17][7:4]);
		smp.ay = join20(pkt[3], pkt[4], pkt[18][7:4]);
		smp.az = join20(pkt[5], pkt[6], pkt[19][7:4]);
		smp.gx = join20(pkt[7], pkt[8], pkt[17][3:0]);
		smp.gy = join20(pkt[9], pkt[10], pkt[18][3:0]);
		smp.gz = join20(pkt[11], pkt[12], pkt[19][3:0]);
		smp.temp = {pkt[13], pkt[14]};
		smp.acc_bad = (smp.ax == INVALID20) || (smp.ay == INVALID20) ||
			(smp.az == INVALID20);
	end

endmodule

// ===== rtl/core/imu_pkt_tsgen.sv =====
// First-packet timestamp: now - (packets-1)*period over two register stages.
// Depends on imu_pkt_pkg.
module imu_pkt_tsgen import imu_pkt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [TS_W-1:0]   now,
	input  logic [PKTS_W-1:0] n1,
	input  logic [PER_W-1:0]  period,
	output ts_load_t          ld
);

	logic                      go_s1, go_s2;
	logic [TS_W-1:0]           now_s1, now_s2;
	logic [PKTS_W-1:0]         n1_s1;
	logic [PKTS_W+PER_W-1:0]   prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= go;
			go_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		now_s1 <= now;
		n1_s1 <= n1;
		now_s2 <= now_s1;
		prod_s2 <= (PKTS_W+PER_W)'(n1_s1) * (PKTS_W+PER_W)'(period);
	end

	always_comb begin
		ld.load = go_s2;
		ld.value = now_s2 - TS_W'(prod_s2);
	end

endmodule

// ===== rtl/core/imu_fifo_packet_parser.sv =====
// Top level of the IMU FIFO packet parser: input register, packet store,
// batch state, result register. Uses imu_pkt_pkg, imu_pkt_decode, imu_pkt_tsgen.
//
// Input channel (in_valid/in_stall): one word per item. opcode 0 starts a
// batch with fifo_count and now_us; opcode 1 carries one FIFO data_byte.
// Output channel (out_valid/out_stall): zero or one result per item, in order.
// status 0 is a sample, 1 a lost frame (header bad, rest of batch dropped),
// 2 a FIFO overflow (count at or above FIFO_BYTES).
// Throughput: one item per cycle while the output is not stalled. An accepted
// item is held in the input register until it can advance; its result is then
// loaded into the output register and shows on out_valid.
// The first-packet timestamp comes from a two-stage multiply/subtract path
// that finishes well before the first packet of a batch can complete.
// While out_valid is high and out_stall is asserted the result holds, and
// in_stall rises once the input register holds a word that cannot move.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 accel
// enable, 1 gyro enable, 2 sample period); write only while idle.
// Reset (arst_n low) clears batch state and out_valid; the period resets to
// 500 and both enables to 0.
module imu_fifo_packet_parser import imu_pkt_pkg::*; #(
	parameter int FIFO_BYTES = FIFO_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [PER_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [7:0]          data_byte,
	input  logic [CNT_W-1:0]    fifo_count,
	input  logic [TS_W-1:0]     now_us,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [19:0]  accel_x,
	output logic signed [19:0]  accel_y,
	output logic signed [19:0]  accel_z,
	output logic signed [19:0]  gyro_x,
	output logic signed [19:0]  gyro_y,
	output logic signed [19:0]  gyro_z,
	output logic signed [15:0]  temperature_raw,
	output logic [TS_W-1:0]     timestamp_us,
	output logic                accel_valid,
	output logic                gyro_valid
);

	localparam logic [CNT_W-1:0] FIFO_LIM = CNT_W'(FIFO_BYTES);

	// configuration
	logic accel_en_q, gyro_en_q;
	logic [PER_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_en_q <= 1'b0;
			gyro_en_q <= 1'b0;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_EN: accel_en_q <= cfg_data[0];
				REG_GYRO_EN:  gyro_en_q <= cfg_data[0];
				REG_PERIOD:   period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1, opcode_s1;
	logic [7:0] byte_s1;
	logic [CNT_W-1:0] count_s1;
	logic [TS_W-1:0] now_s1;
	logic out_valid_q;
	logic advance;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			byte_s1 <= data_byte;
			count_s1 <= fifo_count;
			now_s1 <= now_us;
		end
	end

	// batch state
	logic [POS_W-1:0] byte_pos_q;
	logic [PKTS_W-1:0] pkts_left_q;
	logic [TS_W-1:0] next_ts_q;
	logic [PKT_LEN-2:0][7:0] pkt_q;

	logic fire, is_start, is_data, done, ovf, produce;
	logic [DIV_PROD_W-1:0] div_prod;
	logic [PKTS_W-1:0] pkts;
	pkt_t pkt;
	smp_t smp;
	ts_load_t ts_ld;

	assign fire = valid_s1 && advance;
	assign is_start = fire && (opcode_s1 == OP_START);
	assign is_data = fire && (opcode_s1 == OP_DATA) && (pkts_left_q != '0);
	assign done = is_data && (byte_pos_q == LAST_POS);
	assign ovf = count_s1 >= FIFO_LIM;
	assign div_prod = DIV_PROD_W'(count_s1[CNT_W-1:2]) * DIV_PROD_W'(DIV5_MAGIC);
	assign pkts = div_prod[DIV5_SHIFT +: PKTS_W];

	always_comb begin
		pkt[PKT_LEN-2:0] = pkt_q;
		pkt[PKT_LEN-1] = byte_s1;   // last byte goes straight to decode
	end

	imu_pkt_decode u_decode (
		.pkt(pkt),
		.smp(smp)
	);

	imu_pkt_tsgen u_tsgen (
		.clk(clk),
		.arst_n(arst_n),
		.go(is_start && !ovf && (pkts != '0)),
		.now(now_s1),
		.n1(pkts - PKTS_W'(1)),
		.period(period_q),
		.ld(ts_ld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			pkts_left_q <= '0;
			next_ts_q <= '0;
		end else begin
			if (is_start) begin
				byte_pos_q <= '0;
				pkts_left_q <= ovf ? '0 : pkts;
			end else if (done) begin
				byte_pos_q <= '0;
				pkts_left_q <= smp.hdr_ok ? pkts_left_q - PKTS_W'(1) : '0;
			end else if (is_data) begin
				byte_pos_q <= byte_pos_q + POS_W'(1);
			end
			if (ts_ld.load) begin
				next_ts_q <= ts_ld.value;
			end else if (done) begin
				next_ts_q <= next_ts_q + TS_W'(period_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_data && !done) begin
			pkt_q[byte_pos_q] <= byte_s1;
		end
	end

	// result register
	logic [1:0] status_q;
	logic [19:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [15:0] temp_q;
	logic [TS_W-1:0] ts_q;
	logic aval_q, gval_q;
	logic sample;

	assign sample = done && smp.hdr_ok;
	assign produce = (is_start && ovf) || (done && (!smp.hdr_ok || !smp.acc_bad));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			status_q <= is_start ? ST_OVF : (smp.hdr_ok ? ST_SAMPLE : ST_LOST);
			ax_q <= sample ? smp.ax : '0;
			ay_q <= sample ? smp.ay : '0;
			az_q <= sample ? smp.az : '0;
			gx_q <= sample ? smp.gx : '0;
			gy_q <= sample ? smp.gy : '0;
			gz_q <= sample ? smp.gz : '0;
			temp_q <= sample ? smp.temp : '0;
			ts_q <= is_start ? '0 : next_ts_q;
			aval_q <= sample && accel_en_q;
			gval_q <= sample && gyro_en_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign accel_x = ax_q;
	assign accel_y = ay_q;
	assign accel_z = az_q;
	assign gyro_x = gx_q;
	assign gyro_y = gy_q;
	assign gyro_z = gz_q;
	assign temperature_raw = temp_q;
	assign timestamp_us = ts_q;
	assign accel_valid = aval_q;
	assign gyro_valid = gval_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= LAST_POS)
		else $error("byte position past packet end");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(pkts_left_q == '0) |-> (byte_pos_q == '0))
		else $error("partial packet with no packets expected");

	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_OVF)) |-> ((ts_q == '0) && !aval_q && !gval_q))
		else $error("overflow result carries data");

endmodule

// ===== verif/imu_fifo_packet_parser_tb.sv =====
// Self-checking testbench for imu_fifo_packet_parser: directed batches, setting sweeps,
// output hold-off and random batch traffic against a cycle-free parser predictor.
// Depends on imu_pkt_pkg and the imu_fifo_packet_parser RTL.
`timescale 1ns / 100ps

module imu_fifo_packet_parser_tb;
	import imu_pkt_pkg::*;

	localparam int HOLD_LEN = 400;
	localparam int WDOG_LIMIT = 2000;
	localparam int RAND_ITEMS = 600;
	localparam int MAX_PKTS = (FIFO_BYTES_DEF - 1) / PKT_LEN;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] ax, ay, az, gx, gy, gz;
		logic [15:0] temp;
		logic [63:0] ts;
		logic        av, gv;
	} imu_sample_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [PER_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = OP_START;
	logic [7:0]         data_byte = '0;
	logic [CNT_W-1:0]   fifo_count = '0;
	logic [TS_W-1:0]    now_us = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [19:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
	logic signed [15:0] temperature_raw;
	logic [TS_W-1:0]    timestamp_us;
	logic               accel_valid, gyro_valid;

	// predictor state and its copy of the registers
	logic [7:0]  pkt_buf [PKT_LEN];
	int unsigned pkt_pos = 0;
	logic [15:0] pkts_left = '0;
	logic [63:0] next_ts = '0;
	logic        acc_en_pred = 1'b0;
	logic        gyr_en_pred = 1'b0;
	logic [15:0] period_pred = PERIOD_RST;

	imu_sample_t pending_samples [$];

	int  n_items = 0;
	int  n_errors = 0;
	int  n_samples = 0;
	int  n_lost = 0;
	int  n_ovf = 0;
	int  quiet_cycles = 0;
	int  hold_cnt = 0;
	bit  hold_go = 1'b0;
	bit  calm = 1'b0;

	imu_fifo_packet_parser #(.FIFO_BYTES(FIFO_BYTES_DEF)) dut (.*);

	always #5 clk = ~clk;

	function automatic bit header_ok(input logic [7:0] h);
		return !h[7] && h[6] && h[5] && h[4] && (h[3:2] == 2'b10);
	endfunction

	function automatic logic [19:0] rebuild20(input logic [7:0] hi, input logic [7:0] mid,
			input logic [3:0] lo);
		return {hi, mid, lo};
	endfunction

	task automatic parse_word(input logic op, input logic [7:0] b, input logic [15:0] cnt,
			input logic [63:0] now);
		imu_sample_t r;
		r = '0;
		if (op == OP_START) begin
			pkt_pos = 0;
			if (cnt >= FIFO_BYTES_DEF) begin
				pkts_left = '0;
				r.status = ST_OVF;
				pending_samples.push_back(r);
			end else begin
				pkts_left = 16'(cnt / PKT_LEN);
				if (pkts_left != 0)
					next_ts = now - 64'(pkts_left - 16'd1) * 64'(period_pred);
			end
			return;
		end
		if (pkts_left == 0)
			return;
		pkt_buf[pkt_pos] = b;
		pkt_pos++;
		if (pkt_pos < PKT_LEN)
			return;
		pkt_pos = 0;
		pkts_left--;
		r.ts = next_ts;
		next_ts += 64'(period_pred);
		if (!header_ok(pkt_buf[0])) begin
			pkts_left = '0;
			r.status = ST_LOST;
			pending_samples.push_back(r);
			return;
		end
		r.ax = rebuild20(pkt_buf[1], pkt_buf[2], pkt_buf[17][7:4]);
		r.ay = rebuild20(pkt_buf[3], pkt_buf[4], pkt_buf[18][7:4]);
		r.az = rebuild20(pkt_buf[5], pkt_buf[6], pkt_buf[19][7:4]);
		// sentinel accel: slot used, nothing published
		if (r.ax == INVALID20 || r.ay == INVALID20 || r.az == INVALID20)
			return;
		r.gx = rebuild20(pkt_buf[7], pkt_buf[8], pkt_buf[17][3:0]);
		r.gy = rebuild20(pkt_buf[9], pkt_buf[10], pkt_buf[18][3:0]);
		r.gz = rebuild20(pkt_buf[11], pkt_buf[12], pkt_buf[19][3:0]);
		r.temp = {pkt_buf[13], pkt_buf[14]};
		r.av = acc_en_pred;
		r.gv = gyr_en_pred;
		r.status = ST_SAMPLE;
		pending_samples.push_back(r);
	endtask

	task automatic log_mismatch(input string what, input imu_sample_t want,
			input imu_sample_t got);
		n_errors++;
		if (n_errors <= 10) begin
			$display("%0t mismatch (%s) exp: st=%0d a=%h/%h/%h g=%h/%h/%h t=%h ts=%h v=%b%b",
				$time, what, want.status, want.ax, want.ay, want.az, want.gx, want.gy,
				want.gz, want.temp, want.ts, want.av, want.gv);
			$display("%0t mismatch (%s) got: st=%0d a=%h/%h/%h g=%h/%h/%h t=%h ts=%h v=%b%b",
				$time, what, got.status, got.ax, got.ay, got.az, got.gx, got.gy,
				got.gz, got.temp, got.ts, got.av, got.gv);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		imu_sample_t want, got;
		if (out_valid === 1'b1 && !out_stall) begin
			got = {status, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
				temperature_raw, timestamp_us, accel_valid, gyro_valid};
			if (pending_samples.size() == 0) begin
				want = 'x;
				log_mismatch("no result pending", want, got);
			end else begin
				want = pending_samples.pop_front();
				case (want.status)
					ST_SAMPLE: n_samples++;
					ST_LOST:   n_lost++;
					default:   n_ovf++;
				endcase
				if (got !== want)
					log_mismatch("field", want, got);
			end
		end
	end

	// output stall: random, quiet while calm, solid during a hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			out_stall <= 1'b1;
			if (hold_cnt == HOLD_LEN) begin
				hold_go <= 1'b0;
				hold_cnt <= 0;
			end else
				hold_cnt <= hold_cnt + 1;
		end else
			out_stall <= !calm && ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WDOG_LIMIT) @(posedge clk);
		$display("watchdog: %0d cycles without a handshake, %0d results pending",
			quiet_cycles, pending_samples.size());
		$display("imu_fifo_packet_parser_tb: done, errors");
		$finish;
	end

	task automatic send_word(input logic op, input logic [7:0] b, input logic [15:0] cnt,
			input logic [63:0] now);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		fifo_count <= cnt;
		now_us <= now;
		// stall is settled by the falling edge; the word goes in at the next rising one
		@(negedge clk);
		while (in_stall) @(negedge clk);
		parse_word(op, b, cnt, now);
		n_items++;
		@(posedge clk);
	endtask

	task automatic send_start(input logic [15:0] cnt, input logic [63:0] now);
		send_word(OP_START, 8'($urandom), cnt, now);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(OP_DATA, b, 16'($urandom), {$urandom, $urandom});
	endtask

	task automatic send_packet(input logic [7:0] pb [PKT_LEN], input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte(pb[i]);
	endtask

	task automatic make_packet(output logic [7:0] pb [PKT_LEN], input logic [7:0] hdr,
			input logic [19:0] ax, ay, az, gx, gy, gz, input logic [15:0] temp);
		pb[0] = hdr;
		pb[1] = ax[19:12];
		pb[2] = ax[11:4];
		pb[3] = ay[19:12];
		pb[4] = ay[11:4];
		pb[5] = az[19:12];
		pb[6] = az[11:4];
		pb[7] = gx[19:12];
		pb[8] = gx[11:4];
		pb[9] = gy[19:12];
		pb[10] = gy[11:4];
		pb[11] = gz[19:12];
		pb[12] = gz[11:4];
		pb[13] = temp[15:8];
		pb[14] = temp[7:0];
		pb[15] = 8'($urandom);
		pb[16] = 8'($urandom);
		pb[17] = {ax[3:0], gx[3:0]};
		pb[18] = {ay[3:0], gy[3:0]};
		pb[19] = {az[3:0], gz[3:0]};
	endtask

	task automatic random_packet(output logic [7:0] pb [PKT_LEN]);
		int roll;
		logic [7:0] hdr;
		logic [19:0] ax, ay, az;
		roll = $urandom_range(99);
		hdr = {4'b0111, 2'b10, 2'($urandom)};
		if (roll < 8) begin
			do hdr = 8'($urandom); while (header_ok(hdr));
		end
		ax = 20'($urandom);
		ay = 20'($urandom);
		az = 20'($urandom);
		if (roll >= 8 && roll < 14) begin
			case ($urandom_range(2))
				0: ax = INVALID20;
				1: ay = INVALID20;
				default: az = INVALID20;
			endcase
		end
		make_packet(pb, hdr, ax, ay, az, 20'($urandom), 20'($urandom), 20'($urandom),
			16'($urandom));
	endtask

	// one batch: mostly well-formed, some overflow, empty, cut short or trailed by noise
	task automatic random_batch();
		int kind, npk, nsend, part;
		logic [15:0] cnt;
		logic [63:0] now;
		logic [7:0] pb [PKT_LEN];
		kind = $urandom_range(99);
		// small times make back-dating wrap below zero
		now = ($urandom_range(9) == 0) ? 64'($urandom_range(2000)) : {$urandom, $urandom};
		if (kind < 6) begin
			send_start(16'($urandom_range(FIFO_BYTES_DEF, 65535)), now);
			return;
		end
		if (kind < 12) begin
			send_start(16'($urandom_range(PKT_LEN - 1)), now);
			repeat ($urandom_range(2)) send_byte(8'($urandom));
			return;
		end
		npk = ($urandom_range(99) < 4) ? $urandom_range(5, MAX_PKTS) : $urandom_range(1, 4);
		cnt = 16'(npk * PKT_LEN + $urandom_range(PKT_LEN - 1));
		if (cnt > FIFO_BYTES_DEF - 1)
			cnt = 16'(FIFO_BYTES_DEF - 1);
		send_start(cnt, now);
		nsend = npk;
		part = 0;
		// big batches are always cut short by the next start
		if (npk > 4 || $urandom_range(99) < 10) begin
			nsend = $urandom_range(0, (npk > 3) ? 3 : npk - 1);
			part = $urandom_range(PKT_LEN - 1);
		end
		repeat (nsend) begin
			random_packet(pb);
			send_packet(pb, PKT_LEN);
		end
		if (part != 0) begin
			random_packet(pb);
			send_packet(pb, part);
		end
		if ($urandom_range(99) < 8)
			send_byte(8'($urandom));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
		// a word with no result may still be in flight
		repeat (6) @(posedge clk);
	endtask

	task automatic set_config(input logic a, input logic g, input logic [15:0] p);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACCEL_EN;
		cfg_data <= 16'(a);
		@(posedge clk);
		cfg_index <= REG_GYRO_EN;
		cfg_data <= 16'(g);
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		acc_en_pred = a;
		gyr_en_pred = g;
		period_pred = p;
	endtask

	// runs on reset settings: both enables off, period 500
	task automatic test_directed_cases();
		logic [7:0] pb [PKT_LEN];
		send_start(16'(FIFO_BYTES_DEF), 64'h0123_4567_89ab_cdef);
		send_start(16'hffff, '1);
		send_start(16'd0, 64'd1000);
		send_start(16'(PKT_LEN - 1), 64'd1000);
		send_byte(8'hff);
		send_byte(8'h00);
		// deepest back-dating, then a restart in the middle of a packet
		send_start(16'(FIFO_BYTES_DEF - 1), '1);
		make_packet(pb, 8'h7b, 20'h7ffff, 20'h00001, 20'h80001, 20'h80000, 20'h7ffff,
			20'h00000, 16'h8000);
		send_packet(pb, PKT_LEN);
		make_packet(pb, 8'h78, 20'h12345, 20'hfffff, 20'h00000, 20'hfffff, 20'h80001,
			20'h00001, 16'h7fff);
		send_packet(pb, 5);
		send_start(16'(3 * PKT_LEN), 64'd10);
		make_packet(pb, 8'h79, 20'h00000, INVALID20, 20'h00010, 20'h12345, 20'h54321,
			20'habcde, 16'h0000);
		send_packet(pb, PKT_LEN);
		make_packet(pb, 8'h7a, 20'h80001, 20'h7ffff, 20'hfffff, 20'h00000, 20'h80000,
			20'h7ffff, 16'hffff);
		send_packet(pb, PKT_LEN);
		make_packet(pb, 8'hf8, 20'h11111, 20'h22222, 20'h33333, 20'h44444, 20'h55555,
			20'h66666, 16'h1234);
		send_packet(pb, PKT_LEN);
		send_byte(8'h5a);
		wait_idle();
	endtask

	task automatic test_settings_sweep();
		logic [7:0] pb [PKT_LEN];
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: set_config(1'b1, 1'b1, 16'hffff);
				1: set_config(1'b1, 1'b0, 16'd1);
				default: set_config(1'b0, 1'b1, 16'd0);
			endcase
			send_start(16'(3 * PKT_LEN + 7), {$urandom, $urandom});
			repeat (3) begin
				random_packet(pb);
				send_packet(pb, PKT_LEN);
			end
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		logic [7:0] pb [PKT_LEN];
		set_config(1'b1, 1'b1, 16'($urandom_range(1, 65535)));
		hold_go <= 1'b1;
		// keep offering words while the output is held so the input backs up
		send_start(16'(4 * PKT_LEN), {$urandom, $urandom});
		repeat (4) begin
			random_packet(pb);
			send_packet(pb, PKT_LEN);
		end
		while (hold_go) @(posedge clk);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int start;
		for (int ph = 0; ph < 4; ph++) begin
			set_config(1'($urandom), 1'($urandom), 16'($urandom_range(1, 65535)));
			calm <= (ph == 2);
			start = n_items;
			while (n_items - start < RAND_ITEMS / 4)
				random_batch();
			wait_idle();
			calm <= 1'b0;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_settings_sweep();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		n_errors += pending_samples.size();
		$display("%0d words sent; checked %0d samples, %0d lost frames, %0d overflows",
			n_items, n_samples, n_lost, n_ovf);
		$display("covered reset and swept settings, period 0 to 65535, long output hold-off");
		if (n_errors == 0)
			$display("imu_fifo_packet_parser_tb: done, clean");
		else
			$display("imu_fifo_packet_parser_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/imu_pkt_pkg.sv
rtl/core/imu_pkt_decode.sv
rtl/core/imu_pkt_tsgen.sv
rtl/core/imu_fifo_packet_parser.sv
verif/imu_fifo_packet_parser_tb.sv
